@@ rtl/gnes_pkg.sv @@
package gnes_pkg;

  // Width of the coordinate fields on the item channels.
  localparam int COORD_W = 6;

  // Operation codes carried in the op field of a command item.
  localparam logic OP_FINISH  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Control of the sliding three-row window used during a scan.
  typedef struct packed {
    logic clr;      // empty the window before a new scan
    logic shift;    // advance the window by one row
    logic nxt_vld;  // the incoming row holds real data, otherwise it reads as zero
  } win_ctl_t;

endpackage

@@ rtl/gnes_if.sv @@
// Command channel: one item is a finish notice or a request for a tile.
interface gnes_cmd_if import gnes_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_z;

  modport source (output valid, output op, output cell_x, output cell_z, input ready);
  modport sink   (input valid, input op, input cell_x, input cell_z, output ready);
endinterface

// Result channel: one item per command item.
interface gnes_rsp_if import gnes_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [COORD_W-1:0] grant_x;
  logic [COORD_W-1:0] grant_z;
  logic               all_done;

  modport source (output valid, output granted, output grant_x, output grant_z,
                  output all_done, input ready);
  modport sink   (input valid, input granted, input grant_x, input grant_z,
                  input all_done, output ready);
endinterface

@@ rtl/grid_neighbourhood_exclusion_scheduler.sv @@
// Tile dispatcher for a GRID_X by GRID_Z grid that never has two tiles in
// flight with touching 3x3 neighbourhoods. A finished map and a busy map are
// held in two memories, one GRID_Z-bit row per column x. A request streams
// the rows through a three-row window at one row per cycle until it finds a
// free cell or has passed the last of the GRID_X rows, then on a grant does a
// read-modify-write of up to three busy rows, each a read and a write step.
// A finish item does the same read-modify-write. After reset the block
// clears both memories row by row and takes no item until then. One item
// is worked on at a time; a new item is taken while the previous result
// still waits in the output register.
module grid_neighbourhood_exclusion_scheduler import gnes_pkg::*; #(
  parameter int GRID_X = 64,
  parameter int GRID_Z = 64
) (
  input logic        clk,
  input logic        rst,
  gnes_cmd_if.sink   cmd,
  gnes_rsp_if.source rsp
);

  localparam int XW = $clog2(GRID_X);
  localparam int ZW = $clog2(GRID_Z);
  localparam int CW = XW + 2;
  localparam int FW = XW + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW_RD,
    S_RMW_WR,
    S_OUT
  } state_t;

  state_t            state;
  logic [CW-1:0]     cnt;
  logic              rd_vld;
  logic              ev_vld;
  logic [XW-1:0]     ev_row;
  logic [XW-1:0]     x_q;
  logic [ZW-1:0]     z_q;
  logic              set_mode;
  logic [1:0]        k;
  logic              grant_q;
  logic [FW-1:0]     full_rows;
  logic              res_valid;
  logic              res_granted;
  logic [COORD_W-1:0] res_x;
  logic [COORD_W-1:0] res_z;
  logic              res_done;

  logic              accept;
  logic              in_grid;
  logic [CW-1:0]     rsum;
  logic              rmw_ok;
  logic [XW-1:0]     rmw_row;
  logic [XW-1:0]     rd_addr;
  logic [XW-1:0]     wr_addr;
  logic              busy_we;
  logic              fin_we;
  logic [GRID_Z-1:0] busy_wd;
  logic [GRID_Z-1:0] fin_wd;
  logic [GRID_Z-1:0] busy_rd;
  logic [GRID_Z-1:0] fin_rd;
  logic [GRID_Z+1:0] span;
  logic [GRID_Z-1:0] zmask;
  logic [GRID_Z-1:0] zbit;
  logic [GRID_Z-1:0] fin_new;
  logic              row_full_now;
  win_ctl_t          win_ctl;
  logic              hit;
  logic [ZW-1:0]     hit_z;

  // Handshake.
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_grid   = (32'(cmd.cell_x) < GRID_X) && (32'(cmd.cell_z) < GRID_Z);

  // Row touched by the current read-modify-write step: x - 1 + k, clipped.
  assign rsum    = CW'(x_q) + CW'(k);
  assign rmw_ok  = (rsum != '0) && (rsum <= CW'(GRID_X));
  assign rmw_row = XW'(rsum - CW'(1));

  // Masks along z: the clipped three-cell span and the single cell.
  assign span  = (GRID_Z + 2)'(3'b111) << z_q;
  assign zmask = span[GRID_Z:1];
  assign zbit  = GRID_Z'(1) << z_q;

  assign fin_new      = fin_rd | zbit;
  assign row_full_now = (&fin_new) && !(&fin_rd);

  // Memory port control.
  always_comb begin
    rd_addr = rmw_row;
    wr_addr = rmw_row;
    busy_we = 1'b0;
    fin_we  = 1'b0;
    busy_wd = set_mode ? (busy_rd | zmask) : (busy_rd & ~zmask);
    fin_wd  = fin_new;
    unique case (state)
      S_CLEAR: begin
        wr_addr = cnt[XW-1:0];
        busy_we = 1'b1;
        fin_we  = 1'b1;
        busy_wd = '0;
        fin_wd  = '0;
      end
      S_SCAN: begin
        rd_addr = cnt[XW-1:0];
      end
      S_RMW_WR: begin
        busy_we = 1'b1;
        fin_we  = !set_mode && (k == 2'd1);
      end
      default: begin
      end
    endcase
  end

  gnes_bitmap_mem #(.WIDTH(GRID_Z), .DEPTH(GRID_X)) u_busy_mem (
    .clk (clk),
    .we  (busy_we),
    .wa  (wr_addr),
    .wd  (busy_wd),
    .ra  (rd_addr),
    .rd  (busy_rd)
  );

  gnes_bitmap_mem #(.WIDTH(GRID_Z), .DEPTH(GRID_X)) u_fin_mem (
    .clk (clk),
    .we  (fin_we),
    .wa  (wr_addr),
    .wd  (fin_wd),
    .ra  (rd_addr),
    .rd  (fin_rd)
  );

  // Window control for the scan.
  assign win_ctl.clr     = accept;
  assign win_ctl.shift   = (state == S_SCAN);
  assign win_ctl.nxt_vld = rd_vld;

  gnes_window #(.GRID_Z(GRID_Z)) u_window (
    .clk      (clk),
    .ctl      (win_ctl),
    .busy_row (busy_rd),
    .fin_row  (fin_rd),
    .hit      (hit),
    .hit_z    (hit_z)
  );

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      ev_vld    <= 1'b0;
      full_rows <= '0;
      res_valid <= 1'b0;
      grant_q   <= 1'b0;
      set_mode  <= 1'b0;
      k         <= '0;
    end else begin
      if (rsp.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(GRID_X - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_q      <= XW'(cmd.cell_x);
            z_q      <= ZW'(cmd.cell_z);
            cnt      <= '0;
            rd_vld   <= 1'b0;
            ev_vld   <= 1'b0;
            grant_q  <= 1'b0;
            set_mode <= 1'b0;
            k        <= '0;
            if (cmd.op == OP_REQUEST) begin
              state <= S_SCAN;
            end else if (in_grid) begin
              state <= S_RMW_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          cnt    <= cnt + CW'(1);
          rd_vld <= (cnt < CW'(GRID_X));
          ev_vld <= (cnt >= CW'(2)) && (cnt <= CW'(GRID_X + 1));
          ev_row <= XW'(cnt - CW'(2));
          priority if (ev_vld && hit) begin
            x_q      <= ev_row;
            z_q      <= hit_z;
            set_mode <= 1'b1;
            grant_q  <= 1'b1;
            k        <= '0;
            state    <= S_RMW_RD;
          end else if (ev_vld && (ev_row == XW'(GRID_X - 1))) begin
            state <= S_OUT;
          end
        end
        S_RMW_RD: begin
          priority if (rmw_ok) begin
            state <= S_RMW_WR;
          end else if (k == 2'd2) begin
            state <= S_OUT;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_RMW_WR: begin
          if (fin_we && row_full_now) begin
            full_rows <= full_rows + FW'(1);
          end
          if (k == 2'd2) begin
            state <= S_OUT;
          end else begin
            k     <= k + 2'd1;
            state <= S_RMW_RD;
          end
        end
        S_OUT: begin
          if (!res_valid || rsp.ready) begin
            res_valid   <= 1'b1;
            res_granted <= grant_q;
            res_x       <= grant_q ? COORD_W'(x_q) : '0;
            res_z       <= grant_q ? COORD_W'(z_q) : '0;
            res_done    <= (full_rows == FW'(GRID_X));
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = res_valid;
  assign rsp.granted  = res_granted;
  assign rsp.grant_x  = res_x;
  assign rsp.grant_z  = res_z;
  assign rsp.all_done = res_done;

  // The count of completed rows never passes the number of rows.
  a_full_rows_bound: assert property (@(posedge clk) disable iff (rst)
    full_rows <= FW'(GRID_X))
    else $error("completed row count exceeds grid size");

  // A new result appears only when the sequencer leaves its output step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  // With every cell finished no tile can be granted.
  a_done_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.all_done |-> !rsp.granted)
    else $error("grant reported with every cell finished");

  // The bitmaps stay untouched while a scan streams them.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !busy_we && !fin_we)
    else $error("bitmap written during a scan");

endmodule

@@ rtl/gnes_bitmap_mem.sv @@
// Bitmap store: one row per grid column, one write port and one read port,
// read data registered.
module gnes_bitmap_mem #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

@@ rtl/gnes_window.sv @@
// Sliding three-row window over the busy bitmap. Each shift takes the next
// row, forms the dilated busy mask of the middle row and registers the
// candidate cells of that row; a find-first picks the lowest candidate.
module gnes_window import gnes_pkg::*; #(
  parameter int GRID_Z = 64
) (
  input  logic                      clk,
  input  win_ctl_t                  ctl,
  input  logic [GRID_Z-1:0]         busy_row,
  input  logic [GRID_Z-1:0]         fin_row,
  output logic                      hit,
  output logic [$clog2(GRID_Z)-1:0] hit_z
);

  localparam int ZW = $clog2(GRID_Z);

  logic [GRID_Z-1:0] prev_row;
  logic [GRID_Z-1:0] cur_row;
  logic [GRID_Z-1:0] cur_fin;
  logic [GRID_Z-1:0] cand;
  logic [GRID_Z-1:0] nxt_row;
  logic [GRID_Z-1:0] blk;
  logic [GRID_Z-1:0] dil;

  // Rows outside the grid read as not busy.
  assign nxt_row = ctl.nxt_vld ? busy_row : '0;

  // Busy marks of the three rows, spread by one cell along z.
  assign blk = prev_row | cur_row | nxt_row;
  assign dil = blk | (blk << 1) | (blk >> 1);

  // Window and candidate registers.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      prev_row <= '0;
      cur_row  <= '0;
    end else if (ctl.shift) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
      cur_fin  <= fin_row;
      cand     <= ~cur_fin & ~dil;
    end
  end

  // Lowest candidate cell of the evaluated row.
  always_comb begin
    hit_z = '0;
    for (int i = GRID_Z - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_z = ZW'(i);
      end
    end
  end

  assign hit = |cand;

endmodule
